FILE: hdl/cose_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cose_pkg
// Shared types and constants of the clock offset sync estimator.
// ----------------------------------------------------------------------------
package cose_pkg;

  localparam int STAMP_BITS = 64;
  localparam logic [63:0] STAMP_MASK = {64{1'b1}} >> (64 - STAMP_BITS);

  localparam int DIV_W     = 64;
  localparam int DIVISOR_W = 9;
  localparam int STEP_W    = $clog2(DIV_W + 1);
  localparam int DM_NUM_W  = 24;

  localparam logic [STEP_W-1:0] OFF_STEPS = STEP_W'(DIV_W);
  localparam logic [STEP_W-1:0] DM_STEPS  = STEP_W'(DM_NUM_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd3;

  localparam logic [31:0] TIMER_PERIOD_RESET  = 32'd1000000;
  localparam logic [15:0] ACCEPT_WINDOW_RESET = 16'd2500;
  localparam logic [15:0] MAX_DELAY_RESET     = 16'd6000;
  localparam logic [7:0]  DELAY_SAMPLES_RESET = 8'd10;

  typedef struct packed {
    logic [63:0] receive_stamp;
    logic [63:0] send_stamp;
    logic [15:0] link_delay;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic signed [63:0] clock_offset;
    logic [15:0]        mean_delay;
    logic               locked;
    logic               lock_event;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: hdl/cose_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cose_div
// Shared restoring divider, one quotient bit per cycle. The dividend is
// top-aligned; after N steps the low N bits of the quotient hold the result.
// ----------------------------------------------------------------------------
module cose_div (
  input  logic                               clk,
  input  logic                               rst,
  input  cose_pkg::div_ctrl_t                ctrl,
  input  logic [cose_pkg::DIV_W-1:0]         dividend,
  input  logic [cose_pkg::DIVISOR_W-1:0]     divisor,
  output cose_pkg::div_sts_t                 sts,
  output logic [cose_pkg::DIV_W-1:0]         quotient
);
  import cose_pkg::*;

  logic [STEP_W-1:0]    cnt;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIV_W-1:0]     quo;
  logic [DIVISOR_W:0]   shifted;
  logic                 fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(shifted - {1'b0, dsr});
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIVISOR_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign sts      = '{busy: busy, done: done};
  assign quotient = quo;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a running division");

endmodule

FILE: hdl/clock_offset_sync_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_offset_sync_estimator
// Qualifies sync messages, averages the clock offset and link delay, locks.
// ----------------------------------------------------------------------------
// One message is taken at a time, and in_ready stays low until its result is
// written to the output register. A rejected message passes through the gap,
// check and done states before the next possible transfer. An accepted message
// runs the offset sum through the shared serial divider (64 steps). While the
// delay round is open, the delay mean then goes through the same divider (24
// steps). Otherwise the lock step follows. The divider sets the rate. A
// finished result waits in the output register while the next message is
// taken; the next result holds until that one transfers.
module clock_offset_sync_estimator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cose_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cose_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [cose_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cose_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cose_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_GAP, S_CHECK, S_ABS, S_DIV1, S_BRANCH, S_DIV2, S_LOCK, S_DONE
  } state_t;

  state_t state;

  logic [31:0] timer_period_us;
  logic [15:0] accept_window_us;
  logic [15:0] max_link_delay_us;
  logic [7:0]  delay_samples;

  logic [63:0] prev_receive;
  logic [63:0] offset_total;
  logic [8:0]  offset_samples;
  logic [15:0] delay_mean;
  logic [7:0]  delay_samples_seen;
  logic [63:0] offset_now;
  logic        lock_flag;

  logic [63:0] rx;
  logic [63:0] tx;
  logic [15:0] dly;
  logic [63:0] gap;
  logic [63:0] off;
  logic        pos;
  logic        acc;
  logic        ev;
  logic        neg;
  logic [63:0] mean;
  logic [63:0] lock_sum;

  div_ctrl_t            div_ctrl;
  div_sts_t             div_sts;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [DIV_W-1:0]     div_quotient;

  logic [64:0]         win_lo;
  logic [64:0]         win_hi;
  logic                pass;
  logic [DM_NUM_W-1:0] dm_num;

  assign win_lo = {1'b0, gap} + {49'b0, accept_window_us};
  assign win_hi = {33'b0, timer_period_us} + {49'b0, accept_window_us};
  assign pass   = (win_lo > {33'b0, timer_period_us}) && ({1'b0, gap} < win_hi)
                  && (dly < max_link_delay_us);
  assign dm_num = DM_NUM_W'(delay_mean) * DM_NUM_W'(delay_samples_seen)
                  + DM_NUM_W'(dly);

  assign in_ready = (state == S_IDLE);

  cose_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      timer_period_us    <= TIMER_PERIOD_RESET;
      accept_window_us   <= ACCEPT_WINDOW_RESET;
      max_link_delay_us  <= MAX_DELAY_RESET;
      delay_samples      <= DELAY_SAMPLES_RESET;
      prev_receive       <= '0;
      offset_total       <= '0;
      offset_samples     <= '0;
      delay_mean         <= '0;
      delay_samples_seen <= '0;
      offset_now         <= '0;
      lock_flag          <= 1'b0;
      out_valid          <= 1'b0;
      div_ctrl           <= '0;
      acc                <= 1'b0;
      ev                 <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMER_PERIOD:  timer_period_us   <= cfg_data;
          REG_ACCEPT_WINDOW: accept_window_us  <= cfg_data[15:0];
          REG_MAX_DELAY:     max_link_delay_us <= cfg_data[15:0];
          REG_DELAY_SAMPLES: delay_samples     <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rx    <= in_data.receive_stamp & STAMP_MASK;
            tx    <= in_data.send_stamp & STAMP_MASK;
            dly   <= in_data.link_delay;
            state <= S_GAP;
          end
        end
        S_GAP: begin
          gap          <= (rx - prev_receive) & STAMP_MASK;
          pos          <= rx < tx;
          off          <= (rx < tx) ? (tx - rx) : (rx - tx);
          prev_receive <= rx;
          acc          <= 1'b0;
          ev           <= 1'b0;
          state        <= S_CHECK;
        end
        S_CHECK: begin
          if (pass) begin
            acc            <= 1'b1;
            offset_total   <= offset_total + off;
            offset_samples <= offset_samples + 9'd1;
            state          <= S_ABS;
          end else begin
            state <= S_DONE;
          end
        end
        S_ABS: begin
          neg          <= offset_total[63];
          div_dividend <= offset_total[63] ? (64'd0 - offset_total) : offset_total;
          div_divisor  <= offset_samples;
          div_ctrl     <= '{start: 1'b1, steps: OFF_STEPS};
          state        <= S_DIV1;
        end
        S_DIV1: begin
          div_ctrl.start <= 1'b0;
          if (div_sts.done) begin
            mean  <= neg ? (64'd0 - div_quotient) : div_quotient;
            state <= S_BRANCH;
          end
        end
        S_BRANCH: begin
          if (delay_samples_seen < delay_samples) begin
            offset_now         <= pos ? mean : (64'd0 - mean);
            div_dividend       <= {dm_num, {(DIV_W - DM_NUM_W){1'b0}}};
            div_divisor        <= DIVISOR_W'(delay_samples_seen) + DIVISOR_W'(1);
            div_ctrl           <= '{start: 1'b1, steps: DM_STEPS};
            delay_samples_seen <= delay_samples_seen + 8'd1;
            state              <= S_DIV2;
          end else begin
            lock_sum <= mean + {49'b0, delay_mean[15:1]};
            state    <= S_LOCK;
          end
        end
        S_DIV2: begin
          div_ctrl.start <= 1'b0;
          if (div_sts.done) begin
            delay_mean <= div_quotient[15:0];
            state      <= S_DONE;
          end
        end
        S_LOCK: begin
          offset_now         <= pos ? lock_sum : (64'd0 - lock_sum);
          ev                 <= !lock_flag;
          lock_flag          <= 1'b1;
          offset_total       <= '0;
          offset_samples     <= '0;
          delay_mean         <= '0;
          delay_samples_seen <= '0;
          state              <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.accepted     <= acc;
            out_data.clock_offset <= offset_now;
            out_data.mean_delay   <= delay_mean;
            out_data.locked       <= lock_flag;
            out_data.lock_event   <= ev;
            out_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_event_locked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.lock_event |-> out_data.locked && out_data.accepted
    && (out_data.mean_delay == 16'd0)) else $error("lock event without lock");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_sts.busy) else $error("input taken while divider runs");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == S_DIV1) || (state == S_DIV2))
    else $error("divider result with no consumer");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result valid after reset");

endmodule

FILE: tb/sv/clock_offset_sync_estimator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_offset_sync_estimator_checker
// Watches the message, result and register ports of the offset estimator.
// Every sync message that transfers is run through a local model of the gap and
// delay qualification, offset and delay averaging and lock step; the
// predicted result is queued and compared field by field, in order, with
// each result transfer.
// ----------------------------------------------------------------------------
module clock_offset_sync_estimator_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  cose_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  cose_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [cose_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cose_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              pending,
  output int                              fail_count,
  output int                              msg_count,
  output int                              accept_count,
  output int                              lock_count
);
  import cose_pkg::*;

  logic [31:0] period;
  logic [15:0] window;
  logic [15:0] max_dly;
  logic [7:0]  n_avg;

  logic [63:0] last_rx;
  logic [63:0] off_sum;
  logic [8:0]  off_cnt;
  logic [15:0] dly_avg;
  logic [7:0]  dly_cnt;
  logic [63:0] off_est;
  logic        is_locked;

  out_item_t due_results[$];
  out_item_t want;
  out_item_t got;
  int errors = 0;
  int n_msgs = 0;
  int n_acc = 0;
  int n_lock = 0;

  function automatic out_item_t next_estimate(in_item_t msg);
    logic [63:0] rx;
    logic [63:0] tx;
    logic [63:0] gap;
    logic [63:0] per;
    logic [63:0] dev;
    logic [63:0] diff;
    logic [63:0] mag;
    logic [63:0] avg;
    logic [31:0] dsum;
    logic [15:0] dly;
    logic        toward;
    logic        neg;
    out_item_t   r;
    rx = msg.receive_stamp & STAMP_MASK;
    tx = msg.send_stamp & STAMP_MASK;
    dly = msg.link_delay;
    gap = (rx - last_rx) & STAMP_MASK;
    per = {32'd0, period};
    dev = (gap > per) ? gap - per : per - gap;
    r = '0;
    if (dev < {48'd0, window} && dly < max_dly) begin
      r.accepted = 1'b1;
      toward = rx < tx;
      diff = toward ? tx - rx : rx - tx;
      off_sum = off_sum + diff;
      off_cnt = off_cnt + 9'd1;
      if (off_cnt == 9'd0) begin
        off_cnt = 9'd1;
      end
      neg = off_sum[63];
      mag = neg ? -off_sum : off_sum;
      avg = mag / {55'd0, off_cnt};
      if (neg) begin
        avg = -avg;
      end
      if (dly_cnt < n_avg) begin
        off_est = toward ? avg : -avg;
        dsum = 32'(dly_avg) * 32'(dly_cnt) + 32'(dly);
        dly_avg = 16'(dsum / (32'(dly_cnt) + 32'd1));
        dly_cnt = dly_cnt + 8'd1;
      end else begin
        avg = avg + {48'd0, dly_avg >> 1};
        off_est = toward ? avg : -avg;
        if (!is_locked) begin
          is_locked = 1'b1;
          r.lock_event = 1'b1;
        end
        off_sum = '0;
        off_cnt = '0;
        dly_avg = '0;
        dly_cnt = '0;
        n_lock++;
      end
    end
    last_rx = rx;
    r.clock_offset = off_est;
    r.mean_delay = dly_avg;
    r.locked = is_locked;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      period = TIMER_PERIOD_RESET;
      window = ACCEPT_WINDOW_RESET;
      max_dly = MAX_DELAY_RESET;
      n_avg = DELAY_SAMPLES_RESET;
      last_rx = '0;
      off_sum = '0;
      off_cnt = '0;
      dly_avg = '0;
      dly_cnt = '0;
      off_est = '0;
      is_locked = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMER_PERIOD:  period = cfg_data;
          REG_ACCEPT_WINDOW: window = cfg_data[15:0];
          REG_MAX_DELAY:     max_dly = cfg_data[15:0];
          REG_DELAY_SAMPLES: n_avg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = next_estimate(in_data);
        due_results.push_back(want);
        n_msgs++;
        n_acc += want.accepted;
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        end else begin
          want = due_results.pop_front();
          check_field("accepted", 64'(want.accepted), 64'(got.accepted));
          check_field("clock_offset", want.clock_offset, got.clock_offset);
          check_field("mean_delay", 64'(want.mean_delay), 64'(got.mean_delay));
          check_field("locked", 64'(want.locked), 64'(got.locked));
          check_field("lock_event", 64'(want.lock_event), 64'(got.lock_event));
        end
      end
    end
    pending <= due_results.size();
    fail_count <= errors;
    msg_count <= n_msgs;
    accept_count <= n_acc;
    lock_count <= n_lock;
  end

endmodule

FILE: tb/sv/clock_offset_sync_estimator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_offset_sync_estimator_test
// Stimulus and verdict for the clock offset sync estimator.
// A directed run at the reset settings covers gap and delay limits, stamp
// wrap, extreme send stamps and the first lock; random phases then sweep
// the registers, including their extremes, a zero sample count and a count
// lowered mid-round. Sender bursts and receiver stalls are random, with one
// long output hold that backs the block up.
// ----------------------------------------------------------------------------
module clock_offset_sync_estimator_test;
  import cose_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_START  = 400;
  localparam int HOLD_CYCLES = 1500;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TIMER_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int pending;
  int fail_count;
  int msg_count;
  int accept_count;
  int lock_count;
  int cycles = 0;
  int burst_left = 0;
  int settings = 1;

  logic [31:0] cur_period = TIMER_PERIOD_RESET;
  logic [15:0] cur_window = ACCEPT_WINDOW_RESET;
  logic [15:0] cur_max = MAX_DELAY_RESET;
  logic [7:0]  cur_avg = DELAY_SAMPLES_RESET;
  logic [63:0] last_rx = '0;
  logic [63:0] rx;

  clock_offset_sync_estimator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  clock_offset_sync_estimator_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .fail_count   (fail_count),
    .msg_count    (msg_count),
    .accept_count (accept_count),
    .lock_count   (lock_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t make_msg(bit well);
    in_item_t m;
    longint   dev;
    longint   lo;
    longint   hi;
    int       kind;
    lo = longint'(cur_window) - 1;
    hi = lo;
    if (lo > longint'(cur_period)) begin
      lo = longint'(cur_period);
    end
    kind = $urandom_range(0, 9);
    if (well) begin
      if (kind == 0) begin
        dev = hi;
      end else if (kind == 1) begin
        dev = -lo;
      end else begin
        dev = longint'($urandom_range(0, 32'(lo + hi))) - lo;
      end
      m.receive_stamp = last_rx + 64'(cur_period) + 64'(dev);
      m.link_delay = (kind == 2) ? cur_max - 16'd1 : 16'($urandom_range(0, cur_max - 1));
    end else begin
      case (kind % 4)
        0: begin
          m.receive_stamp = rand64();
          m.link_delay = 16'($urandom());
        end
        1: begin
          m.receive_stamp = $urandom_range(0, 1) ? last_rx + 64'(cur_period) + 64'(cur_window)
                                                 : last_rx + 64'(cur_period) - 64'(cur_window);
          m.link_delay = 16'($urandom_range(0, cur_max - 1));
        end
        2: begin
          m.receive_stamp = last_rx + 64'(cur_period);
          m.link_delay = 16'($urandom_range(cur_max, 16'hFFFF));
        end
        default: begin
          m.receive_stamp = rand64();
          m.link_delay = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
        end
      endcase
    end
    case ($urandom_range(0, 4))
      0: m.send_stamp = m.receive_stamp + 64'($urandom_range(0, 2000000));
      1: m.send_stamp = m.receive_stamp - 64'($urandom_range(0, 2000000));
      2: m.send_stamp = rand64();
      3: m.send_stamp = m.receive_stamp;
      default: m.send_stamp = m.receive_stamp ^ rand64();
    endcase
    return m;
  endfunction

  task automatic send(in_item_t m);
    int gap;
    int r;
    in_data <= m;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_rx = m.receive_stamp;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      r = $urandom_range(0, 9);
      gap = (r < 3) ? 0 : (r < 8) ? $urandom_range(1, 40) : $urandom_range(60, 150);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [31:0] per, logic [15:0] win, logic [15:0] maxd,
                           logic [7:0] navg, int count);
    drain();
    write_reg(REG_TIMER_PERIOD, per);
    write_reg(REG_ACCEPT_WINDOW, 32'(win));
    write_reg(REG_MAX_DELAY, 32'(maxd));
    write_reg(REG_DELAY_SAMPLES, 32'(navg));
    cfg_we <= 1'b0;
    cur_period = per;
    cur_window = win;
    cur_max = maxd;
    cur_avg = navg;
    settings++;
    repeat (count) send(make_msg($urandom_range(0, 99) < 85));
  endtask

  initial begin
    int pct;
    wait (rst == 1'b0);
    repeat (HOLD_START) begin
      @(posedge clk);
      out_ready <= $urandom_range(0, 1);
    end
    @(posedge clk);
    out_ready <= 1'b0;
    repeat (HOLD_CYCLES) @(posedge clk);
    forever begin
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 30;
        2: pct = 70;
        default: pct = 95;
      endcase
      repeat ($urandom_range(20, 300)) begin
        @(posedge clk);
        out_ready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rx = 64'(TIMER_PERIOD_RESET);
    send('{rx, rx + 64'd5000, 16'd100});
    rx = last_rx + 64'(TIMER_PERIOD_RESET) + 64'd2499;
    send('{rx, rx - 64'd3000, 16'd5999});
    rx = last_rx + 64'(TIMER_PERIOD_RESET) + 64'd2500;
    send('{rx, rx, 16'd0});
    rx = last_rx + 64'(TIMER_PERIOD_RESET) - 64'd2499;
    send('{rx, rx, 16'd0});
    rx = last_rx + 64'(TIMER_PERIOD_RESET) - 64'd2500;
    send('{rx, 64'd0, 16'd0});
    rx = last_rx + 64'(TIMER_PERIOD_RESET);
    send('{rx, rx + 64'd1, 16'd6000});
    rx = last_rx + 64'(TIMER_PERIOD_RESET);
    send('{rx, '1, 16'hFFFF});
    rx = last_rx + 64'(TIMER_PERIOD_RESET) + 64'd7;
    send('{rx, '1, 16'd1});
    rx = last_rx + 64'(TIMER_PERIOD_RESET);
    send('{rx, 64'd0, 16'd2});
    rx = 64'hFFFF_FFFF_FFFF_F000;
    send('{rx, rx, 16'd0});
    rx = last_rx + 64'(TIMER_PERIOD_RESET);
    send('{rx, rx - 64'd100, 16'd3});
    repeat (12) send(make_msg(1'b1));

    run_phase(32'd1, 16'd1, 16'd1, 8'd1, 30);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'd255, 300);
    run_phase($urandom_range(1, 32'hFFFF_FFFF), 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 65535)), 8'd0, 25);
    run_phase(TIMER_PERIOD_RESET, ACCEPT_WINDOW_RESET, MAX_DELAY_RESET, 8'd20, 14);
    run_phase(TIMER_PERIOD_RESET, ACCEPT_WINDOW_RESET, MAX_DELAY_RESET, 8'd3, 25);
    run_phase($urandom_range(1, 32'hFFFF_FFFF), 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 65535)), 8'($urandom_range(1, 40)), 30);

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d sync messages, %0d accepted, %0d lock steps, over %0d settings",
             msg_count, accept_count, lock_count, settings);
    $display("including extreme registers, a zero sample count and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: clock_offset_sync_estimator.f
hdl/cose_pkg.sv
hdl/cose_div.sv
hdl/clock_offset_sync_estimator.sv
tb/sv/clock_offset_sync_estimator_checker.sv
tb/sv/clock_offset_sync_estimator_test.sv
